FILE: src/binary_to_decimal_ascii_assert.svh
// Assertion macros shared by the binary_to_decimal_ascii RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

// A condition that must hold at every clock edge.
`define BTDA_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A trigger that must be followed in the next cycle by a consequence.
`define BTDA_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: src/btda_pkg.sv
// Shared constants and elaboration-time helpers for binary_to_decimal_ascii.
// No dependencies; used by the front, queue, back and top level.
package btda_pkg;

	localparam int VALUE_FIELD_BITS   = 32;
	localparam int VALUE_BITS_DEFAULT = 32;
	localparam int DIGIT_CHAR_BITS    = 6;
	localparam int QUEUE_DEPTH        = 2;

	// floor(v * RECIP_TEN / 2**RECIP_SHIFT) equals floor(v / 10) for every v below 2**32.
	localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	// Upper two bits of ASCII '0'; a digit 0..9 fills the lower four.
	localparam logic [1:0] ASCII_ZERO_HI = 2'b11;
	localparam logic [3:0] DIGIT_MAX     = 4'd9;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	function automatic int eff_bits(input int bits);
		return (bits < VALUE_FIELD_BITS) ? bits : VALUE_FIELD_BITS;
	endfunction

	// Decimal digit count of the largest value that fits in the given bits.
	function automatic int max_digits(input int bits);
		logic [67:0] lim;
		logic [67:0] p;
		int          n;
		lim = (68'd1 << bits) - 68'd1;
		p   = 68'd1;
		n   = 0;
		while (p <= lim) begin
			p = p * 68'd10;
			n = n + 1;
		end
		return n;
	endfunction

endpackage

FILE: src/btda_fifo.sv
// Short flip-flop queue that carries converted numbers from the front to the back.
// Depends on btda_pkg and the assertion macro header.
`include "binary_to_decimal_ascii_assert.svh"

module btda_fifo #(
	parameter int WIDTH = 44
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr,
	input  logic [WIDTH-1:0]      wr_data,
	input  logic                  rd,
	output logic [WIDTH-1:0]      rd_data,
	output btda_pkg::queue_status_t status
);

	localparam int DEPTH = btda_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_wr   = wr && !status.full;
	assign do_rd   = rd && !status.empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	`BTDA_ASSERT(a_no_write_when_full, !(wr && status.full), "queue written while full")

endmodule

FILE: src/btda_front.sv
// Front of the converter: accepts a value and peels decimal digits off it,
// least significant first, by multiplying with the reciprocal of ten.
// Depends on btda_pkg and the assertion macro header.
`include "binary_to_decimal_ascii_assert.svh"

module btda_front #(
	parameter int VALUE_BITS = btda_pkg::VALUE_BITS_DEFAULT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic [btda_pkg::VALUE_FIELD_BITS-1:0] value,
	output logic                                  q_wr,
	output logic [btda_pkg::max_digits(btda_pkg::eff_bits(VALUE_BITS))-1:0][3:0] q_digits,
	output logic [$clog2(btda_pkg::max_digits(btda_pkg::eff_bits(VALUE_BITS))+1)-1:0] q_count,
	input  btda_pkg::queue_status_t               q_status
);

	localparam int EFF   = btda_pkg::eff_bits(VALUE_BITS);
	localparam int MAXD  = btda_pkg::max_digits(EFF);
	localparam int CNT_W = $clog2(MAXD + 1);
	localparam int PROD_W = EFF + 32;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_PUSH
	} state_t;

	state_t                     state_q;
	logic [EFF-1:0]             v_q;
	logic [PROD_W-1:0]          prod_q;
	logic [MAXD-1:0][3:0]       digits_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [EFF-4:0]             quot;
	logic [EFF-1:0]             quot_ext;
	logic [3:0]                 rem_digit;

	// Only the low four bits of v - 10*q are needed, since the remainder is below ten.
	assign quot      = prod_q[PROD_W-1:btda_pkg::RECIP_SHIFT];
	assign quot_ext  = {3'b000, quot};
	assign rem_digit = v_q[3:0] - ({quot_ext[0], 3'b000} + {quot_ext[2:0], 1'b0});

	assign full     = (state_q != ST_IDLE);
	assign q_wr     = (state_q == ST_PUSH) && !q_status.full;
	assign q_digits = digits_q;
	assign q_count  = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			v_q      <= '0;
			prod_q   <= '0;
			digits_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (push) begin
						v_q     <= value[EFF-1:0];
						cnt_q   <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= {32'b0, v_q} * {{EFF{1'b0}}, btda_pkg::RECIP_TEN};
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// The newest digit enters at the top, so the most significant ends there.
					digits_q <= {rem_digit, digits_q[MAXD-1:1]};
					cnt_q    <= cnt_q + CNT_W'(1);
					v_q      <= quot_ext;
					state_q  <= (quot == '0) ? ST_PUSH : ST_MUL;
				end
				ST_PUSH: begin
					if (!q_status.full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`BTDA_ASSERT(a_digit_range, (state_q != ST_DIV) || (rem_digit <= btda_pkg::DIGIT_MAX), "remainder out of range")

endmodule

FILE: src/btda_back.sv
// Back of the converter: takes converted numbers from the queue and hands out
// their digits as ASCII, most significant first, one beat per digit.
// Depends on btda_pkg and the assertion macro header.
`include "binary_to_decimal_ascii_assert.svh"

module btda_back #(
	parameter int VALUE_BITS = btda_pkg::VALUE_BITS_DEFAULT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  btda_pkg::queue_status_t               q_status,
	input  logic [btda_pkg::max_digits(btda_pkg::eff_bits(VALUE_BITS))-1:0][3:0] q_digits,
	input  logic [$clog2(btda_pkg::max_digits(btda_pkg::eff_bits(VALUE_BITS))+1)-1:0] q_count,
	output logic                                  q_rd,
	output logic                                  empty,
	input  logic                                  pop,
	output logic [btda_pkg::DIGIT_CHAR_BITS-1:0]  digit_char,
	output logic                                  last
);

	localparam int EFF   = btda_pkg::eff_bits(VALUE_BITS);
	localparam int MAXD  = btda_pkg::max_digits(EFF);
	localparam int CNT_W = $clog2(MAXD + 1);

	logic [MAXD-1:0][3:0] buf_q;
	logic [CNT_W-1:0]     rem_q;
	logic                 valid_q;
	logic                 take;
	logic                 finishing;
	logic                 load;

	assign take      = valid_q && pop;
	assign finishing = take && (rem_q == CNT_W'(1));
	assign load      = (!valid_q || finishing) && !q_status.empty;
	assign q_rd      = load;

	assign empty      = !valid_q;
	assign digit_char = {btda_pkg::ASCII_ZERO_HI, buf_q[MAXD-1]};
	assign last       = (rem_q == CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rem_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			rem_q   <= q_count;
		end else if (finishing) begin
			valid_q <= 1'b0;
		end else if (take) begin
			rem_q <= rem_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= q_digits;
		end else if (take) begin
			buf_q <= {buf_q[MAXD-2:0], 4'h0};
		end
	end

	`BTDA_ASSERT(a_rem_nonzero, !valid_q || (rem_q != '0), "valid number with no digits left")
	`BTDA_ASSERT_NEXT(a_more_digits, valid_q && pop && (rem_q != CNT_W'(1)), valid_q, "number dropped before its last digit")

endmodule

FILE: src/binary_to_decimal_ascii.sv
// Unsigned binary to decimal ASCII converter. Each value pushed in comes out as its
// decimal digits in ASCII, most significant first, no leading zeros, with last set on
// the final digit; zero gives a single '0'. Bits of value at and above VALUE_BITS are
// ignored. The front divides by ten by multiplying with the 32-bit reciprocal of ten,
// a multiply state and a divide state for each digit, then a push state into the queue.
// A two-entry queue lets the front start on the next value while the back hands out
// digits at one beat per cycle while pop is high and digits are ready. No state is kept
// between values.
module binary_to_decimal_ascii #(
	parameter int VALUE_BITS = btda_pkg::VALUE_BITS_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic [btda_pkg::VALUE_FIELD_BITS-1:0] value,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [btda_pkg::DIGIT_CHAR_BITS-1:0] digit_char,
	output logic                                 last
);

	localparam int EFF    = btda_pkg::eff_bits(VALUE_BITS);
	localparam int MAXD   = btda_pkg::max_digits(EFF);
	localparam int CNT_W  = $clog2(MAXD + 1);
	localparam int DATA_W = MAXD * 4 + CNT_W;

	logic                    q_wr;
	logic                    q_rd;
	logic [MAXD-1:0][3:0]    wr_digits;
	logic [CNT_W-1:0]        wr_count;
	logic [MAXD-1:0][3:0]    rd_digits;
	logic [CNT_W-1:0]        rd_count;
	logic [DATA_W-1:0]       rd_data;
	btda_pkg::queue_status_t q_status;

	btda_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.value    (value),
		.q_wr     (q_wr),
		.q_digits (wr_digits),
		.q_count  (wr_count),
		.q_status (q_status)
	);

	btda_fifo #(
		.WIDTH(DATA_W)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data ({wr_digits, wr_count}),
		.rd      (q_rd),
		.rd_data (rd_data),
		.status  (q_status)
	);

	assign rd_digits = rd_data[DATA_W-1:CNT_W];
	assign rd_count  = rd_data[CNT_W-1:0];

	btda_back #(
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_status   (q_status),
		.q_digits   (rd_digits),
		.q_count    (rd_count),
		.q_rd       (q_rd),
		.empty      (empty),
		.pop        (pop),
		.digit_char (digit_char),
		.last       (last)
	);

endmodule

FILE: dv/binary_to_decimal_ascii_checker.sv
// Checker for binary_to_decimal_ascii: watches the push and pop channels, predicts
// the decimal digit beats of every accepted value and compares them in order.
// Depends on btda_pkg for the field widths.
module binary_to_decimal_ascii_checker #(
	parameter int VALUE_BITS = btda_pkg::VALUE_BITS_DEFAULT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	input  logic                                  full,
	input  logic [btda_pkg::VALUE_FIELD_BITS-1:0] value,
	input  logic                                  empty,
	input  logic                                  pop,
	input  logic [btda_pkg::DIGIT_CHAR_BITS-1:0]  digit_char,
	input  logic                                  last,
	output int                                    mismatch_count,
	output int                                    digits_pending
);

	localparam logic [7:0] ASCII_ZERO = 8'd48;
	localparam int         MAX_DIGITS = 20;

	typedef struct {
		logic [btda_pkg::DIGIT_CHAR_BITS-1:0] ch;
		logic                                 is_last;
	} digit_beat_t;

	digit_beat_t expected_digits [$];

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Splits the masked value into decimal digits, least significant first,
	// then queues them most significant first with the final one flagged.
	task automatic enqueue_decimal_digits(input logic [btda_pkg::VALUE_FIELD_BITS-1:0] v_in);
		logic [63:0] v;
		logic [63:0] mask;
		logic [3:0]  rev [MAX_DIGITS];
		int          n;
		digit_beat_t beat;
		logic [7:0]  code;
		mask = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
		v = 64'(v_in) & mask;
		n = 0;
		do begin
			rev[n] = 4'(v % 64'd10);
			v = v / 64'd10;
			n++;
		end while (v != 0 && n < MAX_DIGITS);
		for (int k = 0; k < n; k++) begin
			code = ASCII_ZERO + 8'(rev[n - 1 - k]);
			beat.ch = code[btda_pkg::DIGIT_CHAR_BITS-1:0];
			beat.is_last = (k == n - 1);
			expected_digits.push_back(beat);
		end
	endtask

	always @(posedge clk) begin
		digit_beat_t want;
		if (arst_n) begin
			// Pop side first so that a digit can never match a value pushed in the same beat.
			if (pop && !empty) begin
				if (expected_digits.size() == 0) begin
					report_mismatch($sformatf("unexpected digit beat char=%0d last=%0b",
						digit_char, last));
				end else begin
					want = expected_digits.pop_front();
					if (digit_char !== want.ch)
						report_mismatch($sformatf("digit_char %0d, expected %0d",
							digit_char, want.ch));
					if (last !== want.is_last)
						report_mismatch($sformatf("last %0b, expected %0b on char %0d",
							last, want.is_last, want.ch));
				end
			end
			if (push && !full)
				enqueue_decimal_digits(value);
		end
		digits_pending = expected_digits.size();
	end

endmodule

FILE: dv/binary_to_decimal_ascii_tb.sv
// Testbench top for binary_to_decimal_ascii: clock, reset, value stimulus and
// random pop stalls; checking is done by binary_to_decimal_ascii_checker.
// Depends on btda_pkg, the block and the checker.
module binary_to_decimal_ascii_tb;

	localparam int RANDOM_VALUES = 380;
	localparam int NO_IDLE_COUNT = 120;
	localparam int DRAIN_AT      = 250;
	localparam int IDLE_PERCENT  = 18;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int TAIL_CYCLES   = 40;
	localparam int N_CORNERS     = 22;

	localparam logic [31:0] CORNER_VALUES [N_CORNERS] = '{
		32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
		32'd99999, 32'd100000, 32'd9999999, 32'd10000000, 32'd999999999,
		32'd1000000000, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000,
		32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'd4000000000, 32'd12345
	};

	logic                                   clk;
	logic                                   arst_n;
	logic                                   push;
	logic                                   full;
	logic [btda_pkg::VALUE_FIELD_BITS-1:0]  value;
	logic                                   empty;
	logic                                   pop;
	logic [btda_pkg::DIGIT_CHAR_BITS-1:0]   digit_char;
	logic                                   last;
	int                                     mismatch_count;
	int                                     digits_pending;
	logic                                   idle_en;
	int                                     cycle_count;

	binary_to_decimal_ascii i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.value      (value),
		.empty      (empty),
		.pop        (pop),
		.digit_char (digit_char),
		.last       (last)
	);

	binary_to_decimal_ascii_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.value          (value),
		.empty          (empty),
		.pop            (pop),
		.digit_char     (digit_char),
		.last           (last),
		.mismatch_count (mismatch_count),
		.digits_pending (digits_pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver: one pop decision per falling edge.
	initial begin
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			pop = !(idle_en && $urandom_range(0, 99) < IDLE_PERCENT);
		end
	end

	// Called at a falling edge; returns at the falling edge after the accepting beat.
	task automatic send_value(input logic [31:0] v);
		while (idle_en && $urandom_range(0, 99) < IDLE_PERCENT) begin
			push = 1'b0;
			value = $urandom;
			@(negedge clk);
		end
		push = 1'b1;
		value = v;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		push = 1'b0;
		while (digits_pending != 0)
			@(negedge clk);
	endtask

	// A value with exactly n_digits decimal digits, capped at the 32-bit range.
	function automatic logic [31:0] value_with_digits(input int n_digits);
		logic [63:0] lo;
		logic [63:0] hi;
		lo = 64'd1;
		for (int i = 1; i < n_digits; i++)
			lo = lo * 64'd10;
		hi = lo * 64'd10 - 64'd1;
		if (n_digits == 1)
			lo = 64'd0;
		if (hi > 64'hFFFF_FFFF)
			hi = 64'hFFFF_FFFF;
		return 32'(lo + ({$urandom, $urandom} % (hi - lo + 64'd1)));
	endfunction

	initial begin
		int pick;
		arst_n = 1'b0;
		push = 1'b0;
		value = '0;
		idle_en = 1'b1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < N_CORNERS; i++)
			send_value(CORNER_VALUES[i]);
		wait_drained();

		// Start the random part with a stretch where neither side idles.
		idle_en = 1'b0;
		for (int i = 0; i < RANDOM_VALUES; i++) begin
			if (i == NO_IDLE_COUNT)
				idle_en = 1'b1;
			if (i == DRAIN_AT)
				wait_drained();
			pick = $urandom_range(0, 99);
			if (pick < 70)
				send_value(value_with_digits($urandom_range(1, 10)));
			else if (pick < 85)
				send_value($urandom);
			else
				send_value($urandom_range(0, 20));
		end
		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);

		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
